/* design/sts_pkg.sv */
package sts_pkg;

  typedef enum logic [1:0] {
    MODE_EDGE = 2'd0,
    MODE_BYTE = 2'd1,
    MODE_OVF  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_SYNC_OFFSET  = 3'd0,
    REG_BYTE_TIME    = 3'd1,
    REG_EXPECTED_LAG = 3'd2,
    REG_WINDOW_MIN   = 3'd3,
    REG_WINDOW_MAX   = 3'd4,
    REG_REPEAT_EN    = 3'd5,
    REG_GENERATE_EN  = 3'd6
  } cfg_reg_e;

  localparam logic [7:0]  HDR_FIRST     = 8'hAA;
  localparam logic [7:0]  HDR_SECOND    = 8'hAF;
  localparam logic [19:0] US_PER_SECOND = 20'd1_000_000;
  localparam logic [31:0] HALF_SPAN     = 32'h8000_0000;

  localparam logic [15:0] SYNC_OFFSET_RST  = 16'd672;
  localparam logic [15:0] BYTE_TIME_RST    = 16'd100;
  localparam logic [15:0] EXPECTED_LAG_RST = 16'd120;
  localparam logic [15:0] WINDOW_MIN_RST   = 16'd40;
  localparam logic [15:0] WINDOW_MAX_RST   = 16'd500;

  typedef struct packed {
    logic        done;
    logic [31:0] raw_sec;
  } parse_t;

endpackage

/* design/sts_frame_parser.sv */
module sts_frame_parser import sts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [1:0] mode_i,
  input  logic [7:0] byte_value_i,
  input  logic       gen_en_i,
  output parse_t     parse_o
);

  typedef enum logic [1:0] {
    PH_HEADER0 = 2'd0,
    PH_HEADER1 = 2'd1,
    PH_SECONDS = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] bytes_q [3];
  logic       wr;
  logic       done;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    wr      = 1'b0;
    done    = 1'b0;
    if (step_i && !gen_en_i) begin
      if (mode_i == MODE_OVF) begin
        phase_d = PH_HEADER0;
        cnt_d   = '0;
      end else if (mode_i == MODE_BYTE) begin
        unique case (phase_q)
          PH_HEADER1: begin
            phase_d = (byte_value_i == HDR_SECOND) ? PH_SECONDS : PH_HEADER0;
          end
          PH_SECONDS: begin
            if (cnt_q != 2'd3) begin
              wr    = 1'b1;
              cnt_d = cnt_q + 2'd1;
            end else begin
              cnt_d   = '0;
              phase_d = PH_HEADER0;
              done    = 1'b1;
            end
          end
          default: begin
            phase_d = (byte_value_i == HDR_FIRST) ? PH_HEADER1 : PH_HEADER0;
          end
        endcase
      end
    end
  end

  assign parse_o.done    = done;
  assign parse_o.raw_sec = {byte_value_i, bytes_q[2], bytes_q[1], bytes_q[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      bytes_q[cnt_q] <= byte_value_i;
    end
  end

endmodule

/* design/sts_edge_ram.sv */
module sts_edge_ram #(
  parameter int unsigned EDGE_SLOTS = 8,
  localparam int unsigned AW = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0]           mem_q [EDGE_SLOTS];
  logic [EDGE_SLOTS-1:0] vld_q;
  logic [31:0]           rd_data_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_data_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  // never-written slots read as empty
  assign rdata_o = rd_vld_q ? rd_data_q : '0;

endmodule

/* design/serial_time_sync_receiver_core.sv */
// Flow: an edge, overflow, unused-mode or non-final byte goes from idle straight to the output
// register; a packet-completing byte first does one edge RAM read per slot through a 3-stage
// scoring pipe, then widen, reference and offset steps, before the output register loads.
// Only one item is in flight: the next beat is taken only after the output register has
// loaded the last result, so a stalled output also holds off the input.
// Reset clears the edge RAM valid bits, ring head, parser, offset and synced flag,
// and loads the register defaults; no clearing pass is needed.
module serial_time_sync_receiver_core import sts_pkg::*; #(
  parameter int unsigned EDGE_SLOTS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         byte_value_i,
  input  logic [63:0]        time_us_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               offset_valid_o,
  output logic signed [63:0] offset_us_o,
  output logic [31:0]        synced_second_o,
  output logic               edge_found_o,
  output logic               repeat_valid_o,
  output logic [31:0]        repeat_second_o,
  output logic               synced_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int unsigned AW = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(EDGE_SLOTS + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(EDGE_SLOTS - 1);
  localparam logic [CW-1:0] SLOT_CNT  = CW'(EDGE_SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WIDEN,
    ST_REF,
    ST_OFF,
    ST_OUT
  } state_e;

  // configuration
  logic [15:0] sync_offset_q, byte_time_q, lag_q, wmin_q, wmax_q;
  logic        repeat_en_q, gen_en_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_offset_q <= SYNC_OFFSET_RST;
      byte_time_q   <= BYTE_TIME_RST;
      lag_q         <= EXPECTED_LAG_RST;
      wmin_q        <= WINDOW_MIN_RST;
      wmax_q        <= WINDOW_MAX_RST;
      repeat_en_q   <= 1'b0;
      gen_en_q      <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SYNC_OFFSET:  sync_offset_q <= cfg_data_i;
        REG_BYTE_TIME:    byte_time_q   <= cfg_data_i;
        REG_EXPECTED_LAG: lag_q         <= cfg_data_i;
        REG_WINDOW_MIN:   wmin_q        <= cfg_data_i;
        REG_WINDOW_MAX:   wmax_q        <= cfg_data_i;
        REG_REPEAT_EN:    repeat_en_q   <= cfg_data_i[0];
        REG_GENERATE_EN:  gen_en_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  state_e        state_q;
  logic          accept;
  parse_t        parse;
  logic [AW-1:0] head_q, rd_ptr_q;
  logic [CW-1:0] issue_cnt_q;
  logic          ram_we, ram_re;
  logic [31:0]   ram_rdata;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign ram_we     = accept && (mode_i == MODE_EDGE);
  assign ram_re     = (state_q == ST_SEARCH) && (issue_cnt_q != SLOT_CNT);

  sts_frame_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .mode_i      (mode_i),
    .byte_value_i(byte_value_i),
    .gen_en_i    (gen_en_q),
    .parse_o     (parse)
  );

  sts_edge_ram #(
    .EDGE_SLOTS(EDGE_SLOTS)
  ) u_edge_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (ram_we),
    .waddr_i(head_q),
    .wdata_i(time_us_i[31:0]),
    .re_i   (ram_re),
    .raddr_i(rd_ptr_q),
    .rdata_o(ram_rdata)
  );

  // item and search registers
  logic [63:0] now_q;
  logic        done_q;
  logic [31:0] raw_sec_q, sec_q;
  logic        s0_vld_q, s1_vld_q, s2_vld_q;
  logic [31:0] ts1_q, age1_q, ts2_q, score2_q;
  logic        win2_q;
  logic        found_q;
  logic [31:0] best_ts_q, min_score_q;
  logic [63:0] start_q, ref_q, time_offset_q;
  logic [51:0] prod_q;
  logic        synced_q;

  // output register
  logic        out_valid_q, out_offset_valid_q, out_edge_found_q, out_repeat_valid_q;
  logic        out_synced_q;
  logic [63:0] out_offset_q;
  logic [31:0] out_second_q, out_repeat_second_q;

  logic [31:0] now32, lag32, score;
  logic        win;
  logic [31:0] hi_adj;
  logic [16:0] lead_sum;
  logic        search_idle, out_load;

  assign now32 = now_q[31:0];
  assign lag32 = {16'd0, lag_q};
  assign win   = (ts1_q != '0) && (age1_q >= {16'd0, wmin_q}) && (age1_q <= {16'd0, wmax_q});
  assign score = (age1_q >= lag32) ? (age1_q - lag32) : (lag32 - age1_q);
  assign lead_sum = {1'b0, sync_offset_q} + {1'b0, byte_time_q};
  assign search_idle = (issue_cnt_q == SLOT_CNT) && !s0_vld_q && !s1_vld_q && !s2_vld_q;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    hi_adj = now_q[63:32];
    if ((best_ts_q > now32) && ((best_ts_q - now32) > HALF_SPAN)) begin
      hi_adj = now_q[63:32] - 32'd1;
    end else if ((best_ts_q < now32) && ((now32 - best_ts_q) > HALF_SPAN)) begin
      hi_adj = now_q[63:32] + 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q     <= time_us_i;
      raw_sec_q <= parse.raw_sec;
      sec_q     <= parse.raw_sec + 32'd1;
    end
    ts1_q    <= ram_rdata;
    age1_q   <= now32 - ram_rdata;
    ts2_q    <= ts1_q;
    win2_q   <= win;
    score2_q <= score;
    if (state_q == ST_WIDEN) begin
      start_q <= found_q ? {hi_adj, best_ts_q} : now_q;
      prod_q  <= sec_q * US_PER_SECOND;
    end
    if (state_q == ST_REF) begin
      ref_q <= {12'd0, prod_q} - {47'd0, lead_sum};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q             <= ST_IDLE;
      head_q              <= '0;
      rd_ptr_q            <= '0;
      issue_cnt_q         <= '0;
      done_q              <= 1'b0;
      s0_vld_q            <= 1'b0;
      s1_vld_q            <= 1'b0;
      s2_vld_q            <= 1'b0;
      found_q             <= 1'b0;
      best_ts_q           <= '0;
      min_score_q         <= '1;
      time_offset_q       <= '0;
      synced_q            <= 1'b0;
      out_valid_q         <= 1'b0;
      out_offset_valid_q  <= 1'b0;
      out_edge_found_q    <= 1'b0;
      out_repeat_valid_q  <= 1'b0;
      out_synced_q        <= 1'b0;
      out_offset_q        <= '0;
      out_second_q        <= '0;
      out_repeat_second_q <= '0;
    end else begin
      s0_vld_q <= ram_re;
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s1_vld_q;
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            done_q       <= parse.done;
            found_q      <= 1'b0;
            best_ts_q    <= '0;
            min_score_q  <= '1;
            issue_cnt_q  <= '0;
            rd_ptr_q     <= (head_q == '0) ? LAST_SLOT : head_q - AW'(1);
            if (mode_i == MODE_EDGE) begin
              head_q <= (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
            end
            state_q <= parse.done ? ST_SEARCH : ST_OUT;
          end
        end
        ST_SEARCH: begin
          if (ram_re) begin
            issue_cnt_q <= issue_cnt_q + CW'(1);
            rd_ptr_q    <= (rd_ptr_q == '0) ? LAST_SLOT : rd_ptr_q - AW'(1);
          end
          // newest first; strict compare keeps the newer edge on a tie
          if (s2_vld_q && win2_q && (!found_q || (score2_q < min_score_q))) begin
            found_q     <= 1'b1;
            min_score_q <= score2_q;
            best_ts_q   <= ts2_q;
          end
          if (search_idle) begin
            state_q <= ST_WIDEN;
          end
        end
        ST_WIDEN: state_q <= ST_REF;
        ST_REF:   state_q <= ST_OFF;
        ST_OFF: begin
          time_offset_q <= start_q - ref_q;
          synced_q      <= 1'b1;
          state_q       <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_valid_q         <= 1'b1;
            out_offset_valid_q  <= done_q;
            out_offset_q        <= time_offset_q;
            out_second_q        <= done_q ? sec_q : '0;
            out_edge_found_q    <= done_q && found_q;
            out_repeat_valid_q  <= done_q && repeat_en_q;
            out_repeat_second_q <= (done_q && repeat_en_q) ? raw_sec_q : '0;
            out_synced_q        <= synced_q;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign offset_valid_o  = out_offset_valid_q;
  assign offset_us_o     = out_offset_q;
  assign synced_second_o = out_second_q;
  assign edge_found_o    = out_edge_found_q;
  assign repeat_valid_o  = out_repeat_valid_q;
  assign repeat_second_o = out_repeat_second_q;
  assign synced_o        = out_synced_q;

endmodule
